/* hdl/plo_pkg.sv */
// Types, codes and widths shared by the path length odometer.
// Used by plo_isqrt and path_length_odometer_core.
`timescale 1ns / 1ps
`default_nettype none

package plo_pkg;

	localparam int POS_W     = 24;
	localparam int DEPTH_W   = 16;
	localparam int ACC_W     = 48;
	localparam int TICK_W    = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DIFF_W    = POS_W + 1;
	localparam int SQ_W      = 2 * POS_W + 1;
	localparam int RAD_W     = 2 * DIFF_W;
	localparam int ROOT_W    = RAD_W / 2;

	localparam logic [1:0] KIND_FIX   = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd2;

	localparam logic [TICK_W-1:0]  STALE_LIMIT_RST = 16'd10;
	localparam logic [DEPTH_W-1:0] DEPTH_THR_RST   = 16'd0;
	localparam logic               ENABLE_RST      = 1'b1;

	localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [POS_W-1:0]   x_pos;
		logic signed [POS_W-1:0]   y_pos;
		logic [DEPTH_W-1:0]        depth;
	} cmd_t;

	typedef struct packed {
		logic [ACC_W-1:0] total_distance;
		logic [ACC_W-1:0] distance_at_depth;
		logic             stale;
	} result_t;

endpackage

`default_nettype wire

/* hdl/plo_isqrt.sv */
// Iterative integer square root, one root bit per cycle (restoring method).
// Depends on plo_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module plo_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [plo_pkg::RAD_W-1:0]   radicand,
	output logic                             done,
	output logic [plo_pkg::ROOT_W-1:0]       root
);
	import plo_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic              fits;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(rem_sh - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	a_no_restart : assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("square root restarted while busy");
	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without a running root");
	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("done while still busy");

endmodule

`default_nettype wire

/* hdl/path_length_odometer_core.sv */
// Path length odometer top level: request sequencer, shared squarer, totals.
// Depends on plo_pkg and plo_isqrt.
`timescale 1ns / 1ps
`default_nettype none

// A position fix that follows an earlier fix (with enable set) passes through SQX
// and SQY, one square each on the shared 25x25 multiplier, then SUM, ROOT for the
// bit-serial square root, and DONE, where the totals are updated. Other fixes, time
// ticks and clear requests go from acceptance straight to DONE. The next request is
// taken once the sequencer is back in IDLE, in the same cycle that the result
// appears. A result that is held off stretches the update state.
// One request is in flight at a time; cmd_ready is high only while no request is
// being worked on, and a new request is taken while the last result still waits.
// Each request yields exactly one result carrying both totals and the stale flag.
module path_length_odometer_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_ready,
	input  wire plo_pkg::cmd_t                  cmd,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output plo_pkg::result_t                    result,
	input  wire logic                           cfg_we,
	input  wire logic [plo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [plo_pkg::CFG_W-1:0]      cfg_data
);
	import plo_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]              state_q;
	logic [TICK_W-1:0]       stale_limit_q;
	logic [DEPTH_W-1:0]      depth_thr_q;
	logic                    enable_q;

	logic [1:0]              kind_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	logic [DEPTH_W-1:0]      d_q;
	logic                    acc_q;
	logic signed [DIFF_W-1:0] dx_q;
	logic signed [DIFF_W-1:0] dy_q;
	logic [SQ_W-1:0]         prod_q;
	logic [SQ_W-1:0]         sq_q;
	logic [ROOT_W-1:0]       step_q;

	logic signed [POS_W-1:0] prev_x_q;
	logic signed [POS_W-1:0] prev_y_q;
	logic [DEPTH_W-1:0]      prev_d_q;
	logic                    have_prev_q;
	logic [ACC_W-1:0]        total_q;
	logic [ACC_W-1:0]        depth_acc_q;
	logic [TICK_W-1:0]       ticks_q;
	logic                    stale_q;

	result_t                 result_q;
	logic                    result_valid_q;

	logic                    accept;
	logic                    finish;
	logic signed [DIFF_W-1:0] mul_op;
	logic signed [RAD_W-1:0] mul_p;
	logic [RAD_W-1:0]        rad_sum;
	logic [ROOT_W-1:0]       sqrt_root;
	logic                    sqrt_start;
	logic                    sqrt_done;

	logic [ACC_W:0]          total_sum;
	logic [ACC_W:0]          depth_sum;
	logic [ACC_W-1:0]        total_nx;
	logic [ACC_W-1:0]        depth_nx;
	logic [TICK_W-1:0]       ticks_nx;
	logic                    stale_nx;

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign finish    = (state_q == ST_DONE) && (!result_valid_q || result_ready);

	// shared squarer
	assign mul_op  = (state_q == ST_SQX) ? dx_q : dy_q;
	assign mul_p   = RAD_W'(mul_op * mul_op);
	assign rad_sum = {1'b0, sq_q} + {1'b0, prod_q};

	assign sqrt_start = (state_q == ST_SUM);

	plo_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (rad_sum),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_comb begin
		total_sum = {1'b0, total_q} + {{(ACC_W + 1 - ROOT_W){1'b0}}, step_q};
		depth_sum = {1'b0, depth_acc_q} + {{(ACC_W + 1 - ROOT_W){1'b0}}, step_q};
		total_nx  = total_q;
		depth_nx  = depth_acc_q;
		ticks_nx  = ticks_q;
		stale_nx  = stale_q;
		case (kind_q)
			KIND_FIX: begin
				ticks_nx = '0;
				stale_nx = 1'b0;
				if (acc_q) begin
					total_nx = total_sum[ACC_W] ? ACC_MAX : total_sum[ACC_W-1:0];
					if (prev_d_q > depth_thr_q)
						depth_nx = depth_sum[ACC_W] ? ACC_MAX : depth_sum[ACC_W-1:0];
				end
			end
			KIND_TICK: begin
				if (ticks_q != TICK_MAX)
					ticks_nx = ticks_q + 1'b1;
				if (ticks_nx > stale_limit_q)
					stale_nx = 1'b1;
			end
			KIND_CLEAR: begin
				total_nx = '0;
				depth_nx = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= STALE_LIMIT_RST;
			depth_thr_q   <= DEPTH_THR_RST;
			enable_q      <= ENABLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STALE_LIMIT: stale_limit_q <= cfg_data;
				REG_DEPTH_THR:   depth_thr_q   <= cfg_data;
				REG_ENABLE:      enable_q      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= (cmd.kind == KIND_FIX && enable_q && have_prev_q) ?
						ST_SQX : ST_DONE;
				end
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ROOT;
				ST_ROOT: if (sqrt_done) state_q <= ST_DONE;
				ST_DONE: if (finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the request and its working values
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			x_q    <= cmd.x_pos;
			y_q    <= cmd.y_pos;
			d_q    <= cmd.depth;
			acc_q  <= (cmd.kind == KIND_FIX) && enable_q && have_prev_q;
			dx_q   <= DIFF_W'(cmd.x_pos) - DIFF_W'(prev_x_q);
			dy_q   <= DIFF_W'(cmd.y_pos) - DIFF_W'(prev_y_q);
			step_q <= '0;
		end
		if (state_q == ST_SQX)
			prod_q <= mul_p[SQ_W-1:0];
		if (state_q == ST_SQY) begin
			sq_q   <= prod_q;
			prod_q <= mul_p[SQ_W-1:0];
		end
		if (state_q == ST_ROOT && sqrt_done)
			step_q <= sqrt_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_d_q    <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			depth_acc_q <= '0;
			ticks_q     <= '0;
			stale_q     <= 1'b0;
		end else if (finish) begin
			total_q     <= total_nx;
			depth_acc_q <= depth_nx;
			ticks_q     <= ticks_nx;
			stale_q     <= stale_nx;
			if (kind_q == KIND_FIX && enable_q) begin
				prev_x_q    <= x_q;
				prev_y_q    <= y_q;
				prev_d_q    <= d_q;
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.total_distance    <= total_nx;
			result_q.distance_at_depth <= depth_nx;
			result_q.stale             <= stale_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_one_in_flight : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd_ready) else $error("second request taken while busy");
	a_root_in_state : assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_ROOT) else $error("root done outside root state");
	a_depth_le_total : assert property (@(posedge clk) disable iff (!arst_n)
		depth_acc_q <= total_q) else $error("depth total exceeds total distance");
	a_stale_ticks : assert property (@(posedge clk) disable iff (!arst_n)
		stale_q |-> ticks_q != '0) else $error("stale set with no ticks counted");

endmodule

`default_nettype wire
